// File: rtl/core/zone_file_lexer_assert.svh
// ----------------------------------------------------------------------------
// zone file lexer assertion macros
// shared property forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ZONE_FILE_LEXER_ASSERT_SVH
`define ZONE_FILE_LEXER_ASSERT_SVH

// same-cycle implication
`define ZFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zone file lexer check failed");

// next-cycle implication
`define ZFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zone file lexer check failed");

`endif

// File: rtl/core/zfl_pkg.sv
// ----------------------------------------------------------------------------
// zfl_pkg
// types, token codes and character helpers of the zone file lexer
// ----------------------------------------------------------------------------
`default_nettype none

package zfl_pkg;

  localparam int VALUE_W = 31;

  // result kinds
  localparam logic RK_ECHO   = 1'b0;
  localparam logic RK_TOKEN  = 1'b1;

  // request actions
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_END   = 1'b1;

  // token kinds
  localparam logic [3:0] TK_NUMBER = 4'd0;
  localparam logic [3:0] TK_IP     = 4'd1;
  localparam logic [3:0] TK_NAME   = 4'd2;
  localparam logic [3:0] TK_CLASS  = 4'd3;
  localparam logic [3:0] TK_TYPE   = 4'd4;
  localparam logic [3:0] TK_VAR    = 4'd5;
  localparam logic [3:0] TK_AT     = 4'd6;
  localparam logic [3:0] TK_LPAR   = 4'd7;
  localparam logic [3:0] TK_RPAR   = 4'd8;
  localparam logic [3:0] TK_EOF    = 4'd9;
  localparam logic [3:0] TK_ERROR  = 4'd10;

  // record type codes
  localparam logic [2:0] TC_NONE   = 3'd0;
  localparam logic [2:0] TC_SOA    = 3'd1;
  localparam logic [2:0] TC_A      = 3'd2;
  localparam logic [2:0] TC_MX     = 3'd3;
  localparam logic [2:0] TC_NS     = 3'd4;

  // characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_W      = 8'h57;

  // keyword spellings, last bytes in the low end
  localparam logic [23:0] KW_IN    = 24'h00494E;
  localparam logic [23:0] KW_SOA   = 24'h534F41;
  localparam logic [23:0] KW_A     = 24'h000041;
  localparam logic [23:0] KW_MX    = 24'h004D58;
  localparam logic [23:0] KW_NS    = 24'h004E53;

  typedef struct packed {
    logic       action;
    logic [7:0] char_in;
  } item_t;

  typedef struct packed {
    logic               result_kind;
    logic [3:0]         token_kind;
    logic [2:0]         type_code;
    logic [7:0]         text_char;
    logic [VALUE_W-1:0] number_value;
    logic               value_saturated;
    logic               last_of_run;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic res_t make_echo(input logic [7:0] c);
    res_t r;
    r = '0;
    r.result_kind = RK_ECHO;
    r.text_char   = c;
    return r;
  endfunction

  function automatic res_t make_token(input logic [3:0] tk);
    res_t r;
    r = '0;
    r.result_kind = RK_TOKEN;
    r.token_kind  = tk;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/zfl_if.sv
// ----------------------------------------------------------------------------
// zfl stream interfaces
// valid/ready channels for lexer requests and lexer results
// ----------------------------------------------------------------------------
`default_nettype none

interface zfl_in_if;
  logic           valid;
  logic           ready;
  zfl_pkg::item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface zfl_out_if;
  logic          valid;
  logic          ready;
  zfl_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/core/zone_file_lexer.sv
// ----------------------------------------------------------------------------
// zone_file_lexer
// byte-serial lexer for dns zone-file text with token echo and number scaling
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  in_ch    in   one text byte or an end-of-input mark per request
//  out_ch   out  one echoed character or one completed token per result
//
//  a request is decoded in the cycle it is taken; its 0..2 results land in a
//  two-entry result register and leave one per cycle while out_ch is ready, the
//  first one presented on the cycle after the request is taken
//  one request per cycle while each makes at most one result and out_ch is ready;
//  a request that makes two results (token end by lookahead, suffix, end of input
//  with a token open) holds off the next request until the first result has left;
//  the drain of the result register sets the pace
//  rst is synchronous: lexer back to the start state, result register empty
//  in_ch.ready is low only while results still wait that the next request
//  could overrun; out_ch stalls hold the result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "zone_file_lexer_assert.svh"

module zone_file_lexer (
  input  logic      clk,
  input  logic      rst,
  zfl_in_if.sink    in_ch,
  zfl_out_if.source out_ch
);
  import zfl_pkg::*;

  localparam int VALUE_BITS = VALUE_W;

  // lexer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_NUM     = 4'd1;
  localparam logic [3:0] ST_IP      = 4'd2;
  localparam logic [3:0] ST_REMARK  = 4'd3;
  localparam logic [3:0] ST_NAME    = 4'd4;
  localparam logic [3:0] ST_VAR     = 4'd5;
  localparam logic [3:0] ST_AT      = 4'd6;
  localparam logic [3:0] ST_LPAR    = 4'd7;
  localparam logic [3:0] ST_RPAR    = 4'd8;

  localparam int WIDE_W = VALUE_BITS + 4;

  // saturation limit and per-suffix headroom, all worked out at elaboration
  localparam logic [63:0] LIMIT_W = (64'd1 << VALUE_BITS) - 64'd1;
  localparam logic [VALUE_BITS-1:0] LIMIT = VALUE_BITS'(LIMIT_W);
  localparam logic [VALUE_BITS-1:0] MAX_H = VALUE_BITS'(LIMIT_W / 64'd3600);
  localparam logic [VALUE_BITS-1:0] MAX_D = VALUE_BITS'(LIMIT_W / 64'd86400);
  localparam logic [VALUE_BITS-1:0] MAX_W = VALUE_BITS'(LIMIT_W / 64'd604800);
  localparam logic [WIDE_W-1:0] LIMIT_WIDE = WIDE_W'(LIMIT_W);

  // lexer state
  logic [3:0]            state, state_next;
  logic [23:0]           keyword_chars, keyword_chars_next;
  logic [2:0]            name_length, name_length_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic                  overflow_seen, overflow_seen_next;

  // result register: rbuf0 is presented, rbuf1 waits behind it
  res_t       rbuf0, rbuf1;
  logic [1:0] cnt;

  // results of the request being taken
  res_t       r0, r1;
  logic [1:0] n;

  logic       in_acc;
  logic       out_acc;
  logic [7:0] c;

  assign c       = in_ch.payload.char_in;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // room when empty, or when the only waiting result leaves this cycle
  assign in_ch.ready    = (cnt == 2'd0) || ((cnt == 2'd1) && out_ch.ready);
  assign out_ch.valid   = (cnt != 2'd0);
  assign out_ch.payload = rbuf0;

  // completion result of the open token; value passed in so a suffix can
  // complete the number with its scaled value
  function automatic res_t finish_res(input logic [3:0] st,
                                      input logic [23:0] kw,
                                      input logic [2:0] nl,
                                      input logic [VALUE_BITS-1:0] val,
                                      input logic sat);
    res_t r;
    r = make_token(TK_ERROR);
    unique case (st)
      ST_NUM: begin
        r.token_kind      = TK_NUMBER;
        r.number_value    = VALUE_W'(val);
        r.value_saturated = sat;
      end
      ST_IP:   r.token_kind = TK_IP;
      ST_VAR:  r.token_kind = TK_VAR;
      ST_AT:   r.token_kind = TK_AT;
      ST_LPAR: r.token_kind = TK_LPAR;
      ST_RPAR: r.token_kind = TK_RPAR;
      ST_NAME: begin
        r.token_kind = TK_NAME;
        if (nl == 3'd2 && kw == KW_IN) begin
          r.token_kind = TK_CLASS;
        end else if (nl == 3'd3 && kw == KW_SOA) begin
          r.token_kind = TK_TYPE;
          r.type_code  = TC_SOA;
        end else if (nl == 3'd1 && kw == KW_A) begin
          r.token_kind = TK_TYPE;
          r.type_code  = TC_A;
        end else if (nl == 3'd2 && kw == KW_MX) begin
          r.token_kind = TK_TYPE;
          r.type_code  = TC_MX;
        end else if (nl == 3'd2 && kw == KW_NS) begin
          r.token_kind = TK_TYPE;
          r.type_code  = TC_NS;
        end
      end
      default: r = make_token(TK_ERROR);
    endcase
    return r;
  endfunction

  // decimal digit step, saturating
  logic [WIDE_W-1:0]     acc_wide;
  logic [WIDE_W-1:0]     digit_sum;
  logic                  digit_ovf;
  // suffix scaling, saturating
  logic [VALUE_BITS-1:0] scale_max;
  logic [VALUE_BITS-1:0] scaled;
  logic                  scale_ovf;
  logic [VALUE_BITS-1:0] scaled_val;

  assign acc_wide  = WIDE_W'(acc);
  assign digit_sum = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(c - CH_ZERO);
  assign digit_ovf = digit_sum > LIMIT_WIDE;

  always_comb begin
    case (c)
      CH_H:    scale_max = MAX_H;
      CH_D:    scale_max = MAX_D;
      default: scale_max = MAX_W;
    endcase
    case (c)
      CH_H:    scaled = VALUE_BITS'(acc * VALUE_BITS'(64'd3600));
      CH_D:    scaled = VALUE_BITS'(acc * VALUE_BITS'(64'd86400));
      default: scaled = VALUE_BITS'(acc * VALUE_BITS'(64'd604800));
    endcase
  end

  assign scale_ovf  = acc > scale_max;
  assign scaled_val = scale_ovf ? LIMIT : scaled;

  // one request: state update and up to two results
  always_comb begin
    logic do_start;
    res_t fin;
    res_t rr [2];

    state_next         = state;
    keyword_chars_next = keyword_chars;
    name_length_next   = name_length;
    acc_next           = acc;
    overflow_seen_next = overflow_seen;
    rr[0]              = '0;
    rr[1]              = '0;
    n                  = 2'd0;
    do_start           = 1'b0;
    fin = finish_res(state, keyword_chars, name_length, acc, overflow_seen);

    if (in_ch.payload.action == ACT_END) begin
      // close any open token, then end of file
      if (state != ST_IDLE && state != ST_REMARK) begin
        rr[n[0]] = fin;
        n        = n + 2'd1;
      end
      state_next = ST_IDLE;
      rr[n[0]]   = make_token(TK_EOF);
      n          = n + 2'd1;
    end else begin
      unique case (state)
        ST_IDLE: do_start = 1'b1;
        ST_REMARK: begin
          if (c == CH_LF) begin
            state_next = ST_IDLE;
          end
        end
        ST_NUM: begin
          if (is_digit(c)) begin
            acc_next = digit_ovf ? LIMIT : VALUE_BITS'(digit_sum);
            if (digit_ovf) begin
              overflow_seen_next = 1'b1;
            end
            rr[0] = make_echo(c);
            n     = 2'd1;
          end else if (c == CH_H || c == CH_D || c == CH_W) begin
            // suffix: echo it and complete the scaled number at once
            acc_next           = scaled_val;
            overflow_seen_next = overflow_seen || scale_ovf;
            rr[0]              = make_echo(c);
            rr[1]              = finish_res(state, keyword_chars, name_length,
                                            scaled_val, overflow_seen || scale_ovf);
            n                  = 2'd2;
            state_next         = ST_IDLE;
          end else if (c == CH_DOT) begin
            // digits then a dot: the token is an address
            state_next = ST_IP;
            rr[0]      = make_echo(c);
            n          = 2'd1;
          end else begin
            rr[0]    = fin;
            n        = 2'd1;
            do_start = 1'b1;
          end
        end
        ST_IP: begin
          if (is_digit(c) || c == CH_DOT) begin
            rr[0] = make_echo(c);
            n     = 2'd1;
          end else begin
            rr[0]    = fin;
            n        = 2'd1;
            do_start = 1'b1;
          end
        end
        ST_NAME: begin
          if (is_digit(c) || is_alpha(c) || c == CH_DOT || c == CH_DASH) begin
            keyword_chars_next = {keyword_chars[15:0], c};
            if (name_length != 3'd7) begin
              name_length_next = name_length + 3'd1;
            end
            rr[0] = make_echo(c);
            n     = 2'd1;
          end else begin
            rr[0]    = fin;
            n        = 2'd1;
            do_start = 1'b1;
          end
        end
        ST_VAR: begin
          if (is_alpha(c)) begin
            rr[0] = make_echo(c);
            n     = 2'd1;
          end else begin
            rr[0]    = fin;
            n        = 2'd1;
            do_start = 1'b1;
          end
        end
        ST_AT, ST_LPAR, ST_RPAR: begin
          // single-character tokens end on whatever follows
          rr[0]    = fin;
          n        = 2'd1;
          do_start = 1'b1;
        end
        default: state_next = ST_IDLE;
      endcase

      // byte handled from the start state, maybe after a token end
      if (do_start) begin
        state_next = ST_IDLE;
        if (is_space(c)) begin
          state_next = ST_IDLE;
        end else if (is_digit(c)) begin
          state_next         = ST_NUM;
          acc_next           = VALUE_BITS'(c - CH_ZERO);
          overflow_seen_next = 1'b0;
          rr[n[0]]           = make_echo(c);
          n                  = n + 2'd1;
        end else if (is_alpha(c)) begin
          state_next         = ST_NAME;
          keyword_chars_next = {16'h0000, c};
          name_length_next   = 3'd1;
          rr[n[0]]           = make_echo(c);
          n                  = n + 2'd1;
        end else if (c == CH_DOLLAR || c == CH_AT || c == CH_LPAR || c == CH_RPAR) begin
          case (c)
            CH_DOLLAR: state_next = ST_VAR;
            CH_AT:     state_next = ST_AT;
            CH_LPAR:   state_next = ST_LPAR;
            default:   state_next = ST_RPAR;
          endcase
          rr[n[0]] = make_echo(c);
          n        = n + 2'd1;
        end else if (c == CH_SEMI) begin
          state_next = ST_REMARK;
        end else begin
          // byte that cannot start a token
          rr[n[0]] = make_token(TK_ERROR);
          n        = n + 2'd1;
        end
      end
    end

    // mark the final result of this request
    if (n == 2'd2) begin
      rr[1].last_of_run = 1'b1;
    end else if (n == 2'd1) begin
      rr[0].last_of_run = 1'b1;
    end
    r0 = rr[0];
    r1 = rr[1];
  end

  // lexer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      keyword_chars <= '0;
      name_length   <= '0;
      acc           <= '0;
      overflow_seen <= 1'b0;
    end else if (in_acc) begin
      state         <= state_next;
      keyword_chars <= keyword_chars_next;
      name_length   <= name_length_next;
      acc           <= acc_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // result register fill and drain
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_acc) begin
      cnt <= n;
    end else if (out_acc) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rbuf0 <= r0;
      rbuf1 <= r1;
    end else if (out_acc) begin
      rbuf0 <= rbuf1;
    end
  end

  // a pair leaves its first half unmarked, a lone result is the last one
  `ZFL_ASSERT_NOW(a_pair_first_not_last, cnt == 2'd2, !rbuf0.last_of_run)
  `ZFL_ASSERT_NOW(a_single_is_last, cnt == 2'd1, rbuf0.last_of_run)
  // end of input always leaves an eof result behind and the lexer at rest
  `ZFL_ASSERT_NEXT(a_end_gives_eof, in_acc && in_ch.payload.action == ACT_END,
    state == ST_IDLE && cnt != 2'd0)
  // only number tokens carry a value
  `ZFL_ASSERT_NOW(a_value_only_numbers,
    out_ch.valid && (rbuf0.result_kind == RK_ECHO || rbuf0.token_kind != TK_NUMBER),
    rbuf0.number_value == '0 && !rbuf0.value_saturated)

endmodule

`default_nettype wire

// File: sim/tb_zone_file_lexer.sv
// ----------------------------------------------------------------------------
// tb_zone_file_lexer
// self-checking bench for the zone file lexer: text requests go in over the
// request channel and a token predictor builds the echo and token results
// that each accepted request should cause; every result taken from the
// result channel is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module tb_zone_file_lexer;
  import zfl_pkg::*;

  // numeric limits and suffix scales of the number tokens
  localparam longint unsigned VALUE_LIMIT = (64'd1 << VALUE_W) - 64'd1;
  localparam longint unsigned HOUR_SCALE  = 3600;
  localparam longint unsigned DAY_SCALE   = 86400;
  localparam longint unsigned WEEK_SCALE  = 604800;

  // bench knobs
  localparam int TEXT_TARGET    = 800;   // requests to send
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request or result taken
  localparam int LONG_HOLD      = 400;   // one long result stall
  localparam int TAIL_CYCLES    = 20;    // quiet cycles after the last result

  // scanner states of the predictor
  typedef enum int {
    LS_START, LS_NUM, LS_IP, LS_COMMENT, LS_NAME, LS_VAR, LS_AT, LS_LPAR, LS_RPAR
  } lex_state_e;

  // --------------------------------------------------------------------------
  // token predictor: keeps its own scanner state, turns each request into the
  // results it should cause and holds them until they come back from the dut
  // --------------------------------------------------------------------------
  class token_predictor;
    lex_state_e      st;
    logic [23:0]     kw;
    int unsigned     nlen;
    longint unsigned acc;
    bit              ovf;
    res_t            step_results[$];
    res_t            pending_results[$];
    int              errors;
    int              results_checked;
    int              echoes_seen;
    int              saturated_seen;
    int              kind_seen[16];

    function new();
      st = LS_START;
      kw = '0;
      nlen = 0;
      acc = 0;
      ovf = 1'b0;
      errors = 0;
      results_checked = 0;
      echoes_seen = 0;
      saturated_seen = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void push_echo(logic [7:0] c);
      res_t r;
      r = '0;
      r.result_kind = RK_ECHO;
      r.text_char = c;
      step_results.insert(step_results.size(), r);
    endfunction

    function void push_token(logic [3:0] tk, logic [2:0] tc, longint unsigned val, bit sat);
      res_t r;
      r = '0;
      r.result_kind = RK_TOKEN;
      r.token_kind = tk;
      r.type_code = tc;
      r.number_value = val[VALUE_W-1:0];
      r.value_saturated = sat;
      step_results.insert(step_results.size(), r);
    endfunction

    // close whatever token is open; comment and start states give nothing
    function void close_token();
      logic [3:0] tk;
      logic [2:0] tc;
      tc = TC_NONE;
      case (st)
        LS_NUM: begin
          st = LS_START;
          push_token(TK_NUMBER, TC_NONE, acc, ovf);
          return;
        end
        LS_IP:   tk = TK_IP;
        LS_VAR:  tk = TK_VAR;
        LS_AT:   tk = TK_AT;
        LS_LPAR: tk = TK_LPAR;
        LS_RPAR: tk = TK_RPAR;
        LS_NAME: begin
          tk = TK_NAME;
          if (nlen == 2 && kw == KW_IN) begin
            tk = TK_CLASS;
          end else if (nlen == 3 && kw == KW_SOA) begin
            tk = TK_TYPE;
            tc = TC_SOA;
          end else if (nlen == 1 && kw == KW_A) begin
            tk = TK_TYPE;
            tc = TC_A;
          end else if (nlen == 2 && kw == KW_MX) begin
            tk = TK_TYPE;
            tc = TC_MX;
          end else if (nlen == 2 && kw == KW_NS) begin
            tk = TK_TYPE;
            tc = TC_NS;
          end
        end
        default: begin
          st = LS_START;
          return;
        end
      endcase
      st = LS_START;
      push_token(tk, tc, 0, 1'b0);
    endfunction

    // a byte seen from the start state
    function void open_token(logic [7:0] c);
      st = LS_START;
      if (blank(c)) return;
      if (digit(c)) begin
        st = LS_NUM;
        acc = 64'(c - CH_ZERO);
        ovf = 1'b0;
        push_echo(c);
      end else if (letter(c)) begin
        st = LS_NAME;
        kw = {16'h0, c};
        nlen = 1;
        push_echo(c);
      end else begin
        case (c)
          CH_DOLLAR: begin
            st = LS_VAR;
            push_echo(c);
          end
          CH_AT: begin
            st = LS_AT;
            push_echo(c);
          end
          CH_LPAR: begin
            st = LS_LPAR;
            push_echo(c);
          end
          CH_RPAR: begin
            st = LS_RPAR;
            push_echo(c);
          end
          CH_SEMI: st = LS_COMMENT;
          default: push_token(TK_ERROR, TC_NONE, 0, 1'b0);
        endcase
      end
    endfunction

    function void scale_value(longint unsigned factor);
      if (acc > VALUE_LIMIT / factor) begin
        acc = VALUE_LIMIT;
        ovf = 1'b1;
      end else begin
        acc = acc * factor;
      end
    endfunction

    // predict one accepted request; returns how many results it causes
    function int note_request(item_t it);
      logic [7:0] c;
      longint unsigned d;
      res_t last;
      c = it.char_in;
      step_results.delete();
      if (it.action == ACT_END) begin
        if (st != LS_START && st != LS_COMMENT) close_token();
        st = LS_START;
        push_token(TK_EOF, TC_NONE, 0, 1'b0);
      end else begin
        case (st)
          LS_START: open_token(c);
          LS_COMMENT: if (c == CH_LF) st = LS_START;
          LS_NUM: begin
            if (digit(c)) begin
              d = 64'(c - CH_ZERO);
              if (acc > (VALUE_LIMIT - d) / 10) begin
                acc = VALUE_LIMIT;
                ovf = 1'b1;
              end else begin
                acc = acc * 10 + d;
              end
              push_echo(c);
            end else if (c == CH_H || c == CH_D || c == CH_W) begin
              scale_value(c == CH_H ? HOUR_SCALE : (c == CH_D ? DAY_SCALE : WEEK_SCALE));
              push_echo(c);
              close_token();
            end else if (c == CH_DOT) begin
              st = LS_IP;
              push_echo(c);
            end else begin
              close_token();
              open_token(c);
            end
          end
          LS_IP: begin
            if (digit(c) || c == CH_DOT) begin
              push_echo(c);
            end else begin
              close_token();
              open_token(c);
            end
          end
          LS_NAME: begin
            if (digit(c) || letter(c) || c == CH_DOT || c == CH_DASH) begin
              kw = {kw[15:0], c};
              if (nlen < 7) nlen++;
              push_echo(c);
            end else begin
              close_token();
              open_token(c);
            end
          end
          LS_VAR: begin
            if (letter(c)) begin
              push_echo(c);
            end else begin
              close_token();
              open_token(c);
            end
          end
          default: begin
            close_token();
            open_token(c);
          end
        endcase
      end
      if (step_results.size() > 0) begin
        last = step_results[step_results.size() - 1];
        last.last_of_run = 1'b1;
        step_results[step_results.size() - 1] = last;
      end
      foreach (step_results[i]) pending_results.insert(pending_results.size(), step_results[i]);
      return step_results.size();
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // compare one result taken from the dut with the oldest prediction
    function void check_result(res_t got);
      res_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
      compare_field("token_kind", 64'(want.token_kind), 64'(got.token_kind));
      compare_field("type_code", 64'(want.type_code), 64'(got.type_code));
      compare_field("text_char", 64'(want.text_char), 64'(got.text_char));
      compare_field("number_value", 64'(want.number_value), 64'(got.number_value));
      compare_field("value_saturated", 64'(want.value_saturated),
                    64'(got.value_saturated));
      compare_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
      if (want.result_kind == RK_ECHO) begin
        echoes_seen++;
      end else begin
        kind_seen[want.token_kind]++;
        if (want.value_saturated) saturated_seen++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  zfl_in_if  in_ch();
  zfl_out_if out_ch();

  zone_file_lexer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  token_predictor book = new();

  item_t text_queue[$];      // requests of the fragment being built
  int    requests_sent = 0;
  int    text_requests = 0;  // requests that caused at least one result
  int    end_marks     = 0;
  bit    burst_mode    = 1'b0;

  // short gaps mostly, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (burst_mode) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    return idle_length();
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // offer one request at the falling edge, hold it until taken at a rising edge
  task automatic send_request(input item_t it);
    int gap;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
    if (it.action == ACT_END) end_marks++;
    if (book.note_request(it) > 0) text_requests++;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic add_byte(input logic [7:0] c);
    item_t it;
    it.action  = ACT_BYTE;
    it.char_in = c;
    text_queue.insert(text_queue.size(), it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // end mark; the byte field carries junk the block must ignore
  task automatic add_end();
    item_t it;
    it.action  = ACT_END;
    it.char_in = 8'($urandom_range(0, 255));
    text_queue.insert(text_queue.size(), it);
  endtask

  task automatic send_queue();
    while (text_queue.size() > 0) send_request(text_queue.pop_front());
  endtask

  // wait until every predicted result has come back
  task automatic drain_results();
    while (book.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_name_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return rand_letter();
    if (r < 8) return rand_digit();
    if (r == 8) return CH_DOT;
    return CH_DASH;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 7))
      0, 1, 2: return " ";
      3:       return 8'd9;
      4, 5:    return CH_LF;
      6:       return 8'd13;
      default: return 8'($urandom_range(11, 12));
    endcase
  endfunction

  // one piece of zone text with random content, mostly well formed
  task automatic build_fragment();
    string keywords[10];
    int    pick;
    int    len;
    keywords = '{"IN", "SOA", "A", "MX", "NS", "in", "Soa", "NSA", "SOAA", "mx"};
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      // owner names, keywords and near misses
      if ($urandom_range(0, 2) == 0) begin
        add_text(keywords[$urandom_range(0, 9)]);
      end else begin
        add_byte(rand_letter());
        len = $urandom_range(0, 7);
        repeat (len) add_byte(rand_name_char());
      end
    end else if (pick < 46) begin
      // ttl-like numbers, long ones run into saturation
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      repeat (len) add_byte(rand_digit());
      case ($urandom_range(0, 5))
        0: add_byte(CH_H);
        1: add_byte(CH_D);
        2: add_byte(CH_W);
        default: ;
      endcase
    end else if (pick < 54) begin
      // dotted address
      len = $urandom_range(1, 4);
      for (int g = 0; g < len; g++) begin
        if (g > 0) add_byte(CH_DOT);
        repeat ($urandom_range(1, 3)) add_byte(rand_digit());
      end
      if (len == 1) add_byte(CH_DOT);
    end else if (pick < 60) begin
      add_byte(CH_DOLLAR);
      repeat ($urandom_range(0, 6)) add_byte(rand_letter());
    end else if (pick < 68) begin
      case ($urandom_range(0, 2))
        0: add_byte(CH_AT);
        1: add_byte(CH_LPAR);
        default: add_byte(CH_RPAR);
      endcase
    end else if (pick < 76) begin
      // comment with arbitrary bytes, closed by newline or by end of input
      add_byte(CH_SEMI);
      repeat ($urandom_range(0, 10)) begin
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        add_byte(b == CH_LF ? 8'h20 : b);
      end
      if ($urandom_range(0, 9) == 0) add_end();
      else add_byte(CH_LF);
    end else if (pick < 85) begin
      // noise: any byte, many of them unknown to the lexer
      add_byte(8'($urandom_range(0, 255)));
    end else if (pick < 89) begin
      add_end();
    end else begin
      repeat ($urandom_range(1, 4)) add_byte(rand_blank());
    end
    // separator: often none, so tokens also end by the next token's byte
    if ($urandom_range(0, 9) >= 4) add_byte(rand_blank());
  endtask

  // --------------------------------------------------------------------------
  // result side: ready with random stalls, one long stall once the run is warm
  // --------------------------------------------------------------------------
  initial begin
    bit long_hold_done;
    int run;
    long_hold_done = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!long_hold_done && book.results_checked >= 300) begin
        // long stall: the result register fills and the request side backs up
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_done = 1'b1;
      end
      run = $urandom_range(1, 30);
      @(negedge clk);
      out_ch.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      if ($urandom_range(0, 2) != 0) begin
        run = idle_length();
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  // every result taken is checked at the rising edge that takes it
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) book.check_result(out_ch.payload);
  end

  // --------------------------------------------------------------------------
  // watchdog: no request and no result taken for too long ends the run
  // --------------------------------------------------------------------------
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: watchdog, no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit paused;
    paused = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: suffix ends a number, number turns into an address that a
    // paren ends, at-sign ended by a variable, the variable ended by an unknown
    // high byte, a nul byte, name closed by end of input, repeated end marks,
    // end of input inside a comment, keyword, lower case suffix letter
    add_text("9W1.2)@$xNSAB");
    add_byte(8'hFF);
    add_byte(8'h00);
    add_text("a");
    add_end();
    add_end();
    add_byte(CH_SEMI);
    add_end();
    add_text("MX 7h");
    send_queue();

    // random zone text
    while (requests_sent < TEXT_TARGET) begin
      // a stretch of back-to-back requests around the long result stall
      burst_mode = (requests_sent >= 200 && requests_sent < 320);
      if (!paused && requests_sent >= 450) begin
        // request side goes idle and waits until every predicted result is home
        @(negedge clk);
        in_ch.valid <= 1'b0;
        drain_results();
        paused = 1'b1;
      end
      build_fragment();
      send_queue();
    end
    add_end();
    send_queue();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.pending() != 0) begin
      book.errors++;
      $display("%0t: %0d expected results never came", $time, book.pending());
    end

    $display("covered %0d requests (%0d with results, %0d end marks): %0d echoed bytes, %0d results checked",
             requests_sent, text_requests, end_marks, book.echoes_seen, book.results_checked);
    $display("tokens: num %0d (sat %0d) ip %0d name %0d class %0d type %0d var %0d err %0d eof %0d",
             book.kind_seen[TK_NUMBER], book.saturated_seen, book.kind_seen[TK_IP],
             book.kind_seen[TK_NAME], book.kind_seen[TK_CLASS], book.kind_seen[TK_TYPE],
             book.kind_seen[TK_VAR], book.kind_seen[TK_ERROR], book.kind_seen[TK_EOF]);
    if (book.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
